// ===== hw/rtl/double_ended_queue_with_dump_assert.svh =====
// Assertion macros shared by the double-ended queue RTL modules.
`ifndef DOUBLE_ENDED_QUEUE_WITH_DUMP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DUMP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside of reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define DEQ_ASSERT_IMPL(label, pre, post, msg) \
  `DEQ_ASSERT(label, (pre) |-> (post), msg)
`else
`define DEQ_ASSERT(label, prop, msg)
`define DEQ_ASSERT_IMPL(label, pre, post, msg)
`endif

`endif

// ===== hw/rtl/deq_pkg.sv =====
// Types and codes shared by the double-ended queue modules.
package deq_pkg;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DUMP_FWD   = 3'd4,
    REQ_DUMP_BWD   = 3'd5
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ITEM  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  // Queue update operations applied by the datapath.
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    op_e     op;
    logic    load_resp;
    status_e resp_status;
    logic    dump_start;
    logic    dump_bwd;
    logic    rd_issue;
    logic    rd_load;
    logic    load_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic rd_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/deq_chan_if.sv =====
// Valid/ready channel interfaces for requests and results of the queue.
interface deq_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic signed [31:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] item_value;
  logic [1:0]        status;
  logic              last;

  modport source (output valid, output item_value, output status, output last, input ready);
  modport sink (input valid, input item_value, input status, input last, output ready);
endinterface

// ===== hw/rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Controller state machine: request decode and dump read sequencing.
module deq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic [2:0]          req_type_i,
  output logic                req_ready_o,
  input  deq_pkg::dp_status_t status_i,
  output deq_pkg::ctrl_cmd_t  cmd_o
);

  `include "double_ended_queue_with_dump_assert.svh"

  deq_pkg::state_e state_q, state_d;
  logic rd_v_q, rd_v_d;
  logic rd_last_q, rd_last_d;
  logic issued_all_q, issued_all_d;
  logic can_load;

  // State and dump tracking registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= deq_pkg::S_IDLE;
      rd_v_q       <= 1'b0;
      rd_last_q    <= 1'b0;
      issued_all_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_v_q       <= rd_v_d;
      rd_last_q    <= rd_last_d;
      issued_all_q <= issued_all_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    rd_v_d       = rd_v_q;
    rd_last_d    = rd_last_q;
    issued_all_d = issued_all_q;
    req_ready_o  = 1'b0;
    can_load     = 1'b0;
    cmd_o        = '0;
    cmd_o.op          = deq_pkg::OP_NONE;
    cmd_o.resp_status = deq_pkg::ST_DONE;

    case (state_q)
      deq_pkg::S_IDLE: begin
        req_ready_o = !status_i.out_busy;
        if (req_valid_i && !status_i.out_busy) begin
          cmd_o.load_resp = 1'b1;
          case (deq_pkg::req_e'(req_type_i))
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
              if (status_i.full) begin
                cmd_o.resp_status = deq_pkg::ST_FULL;
              end else begin
                cmd_o.op = (deq_pkg::req_e'(req_type_i) == deq_pkg::REQ_PUSH_FRONT) ?
                           deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
              end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
              if (status_i.empty) begin
                cmd_o.resp_status = deq_pkg::ST_EMPTY;
              end else begin
                cmd_o.op = (deq_pkg::req_e'(req_type_i) == deq_pkg::REQ_POP_FRONT) ?
                           deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
              end
            end
            deq_pkg::REQ_DUMP_FWD, deq_pkg::REQ_DUMP_BWD: begin
              if (status_i.empty) begin
                cmd_o.resp_status = deq_pkg::ST_EMPTY;
              end else begin
                cmd_o.load_resp  = 1'b0;
                cmd_o.dump_start = 1'b1;
                cmd_o.dump_bwd   = (deq_pkg::req_e'(req_type_i) == deq_pkg::REQ_DUMP_BWD);
                rd_v_d       = 1'b0;
                rd_last_d    = 1'b0;
                issued_all_d = 1'b0;
                state_d      = deq_pkg::S_DUMP;
              end
            end
            default: begin
              cmd_o.resp_status = deq_pkg::ST_DONE;
            end
          endcase
        end
      end
      deq_pkg::S_DUMP: begin
        // A read result moves to the output register once that register frees up.
        can_load        = rd_v_q && !status_i.out_busy;
        cmd_o.rd_load   = can_load;
        cmd_o.load_last = rd_last_q;
        cmd_o.rd_issue  = !issued_all_q && (!rd_v_q || can_load);
        rd_v_d          = cmd_o.rd_issue || (rd_v_q && !can_load);
        if (cmd_o.rd_issue) begin
          rd_last_d    = status_i.rd_last;
          issued_all_d = status_i.rd_last;
        end
        if (can_load && rd_last_q) begin
          state_d = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::S_IDLE;
      end
    endcase
  end

  // No request is taken while a dump is running.
  `DEQ_ASSERT_IMPL(a_no_accept_in_dump, state_q == deq_pkg::S_DUMP, !req_ready_o,
                   "request accepted during dump")
  // No read is issued once the final entry has been read.
  `DEQ_ASSERT_IMPL(a_no_extra_read, cmd_o.rd_issue, !issued_all_q, "read issued past last entry")
  // No read result is left pending outside of a dump.
  `DEQ_ASSERT_IMPL(a_idle_no_read, state_q == deq_pkg::S_IDLE, !rd_v_q,
                   "read pending while idle")

endmodule

// ===== hw/rtl/deq_datapath.sv =====
// Datapath: head and count registers, entry RAM and the result register.
module deq_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  deq_pkg::ctrl_cmd_t  cmd_i,
  input  logic signed [31:0]  push_value_i,
  input  logic                rsp_ready_i,
  output deq_pkg::dp_status_t status_o,
  output logic                rsp_valid_o,
  output logic signed [31:0]  item_value_o,
  output logic [1:0]          rsp_status_o,
  output logic                rsp_last_o
);

  `include "double_ended_queue_with_dump_assert.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CountMax = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IdxMax   = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] SumDepth = SUM_W'(DEPTH);

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] off_q, off_d;
  logic             bwd_q, bwd_d;
  logic             out_v_q, out_v_d;
  logic [31:0]      out_value_q, out_value_d;
  deq_pkg::status_e out_status_q, out_status_d;
  logic             out_last_q, out_last_d;

  logic [IDX_W-1:0] head_dec, head_inc;
  logic [SUM_W-1:0] tail_sum, rd_sum;
  logic [CNT_W-1:0] rd_off;
  logic [IDX_W-1:0] tail_slot, rd_slot;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_rdata;

  // Circular index arithmetic.
  always_comb begin
    head_dec  = (head_q == '0) ? IdxMax : head_q - 1'b1;
    head_inc  = (head_q == IdxMax) ? '0 : head_q + 1'b1;
    tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
    tail_slot = (tail_sum >= SumDepth) ? IDX_W'(tail_sum - SumDepth) : IDX_W'(tail_sum);
    rd_off    = bwd_q ? (count_q - 1'b1 - off_q) : off_q;
    rd_sum    = SUM_W'(head_q) + SUM_W'(rd_off);
    rd_slot   = (rd_sum >= SumDepth) ? IDX_W'(rd_sum - SumDepth) : IDX_W'(rd_sum);
  end

  // Status back to the controller.
  always_comb begin
    status_o.empty    = (count_q == '0);
    status_o.full     = (count_q == CountMax);
    status_o.rd_last  = (off_q == count_q - 1'b1);
    status_o.out_busy = out_v_q && !rsp_ready_i;
  end

  // Queue pointer updates and the push write.
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_waddr = tail_slot;
    case (cmd_i.op)
      deq_pkg::OP_PUSH_FRONT: begin
        head_d    = head_dec;
        count_d   = count_q + 1'b1;
        ram_we    = 1'b1;
        ram_waddr = head_dec;
      end
      deq_pkg::OP_PUSH_BACK: begin
        count_d = count_q + 1'b1;
        ram_we  = 1'b1;
      end
      deq_pkg::OP_POP_FRONT: begin
        head_d  = head_inc;
        count_d = count_q - 1'b1;
      end
      deq_pkg::OP_POP_BACK: begin
        count_d = count_q - 1'b1;
      end
      default: begin
        head_d  = head_q;
      end
    endcase
  end

  // Dump offset and direction.
  always_comb begin
    off_d = off_q;
    bwd_d = bwd_q;
    if (cmd_i.dump_start) begin
      off_d = '0;
      bwd_d = cmd_i.dump_bwd;
    end else if (cmd_i.rd_issue) begin
      off_d = off_q + 1'b1;
    end
  end

  // Result register: loaded by a single result or by a dumped entry.
  always_comb begin
    out_v_d      = out_v_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (cmd_i.load_resp) begin
      out_v_d      = 1'b1;
      out_value_d  = '0;
      out_status_d = cmd_i.resp_status;
      out_last_d   = 1'b1;
    end else if (cmd_i.rd_load) begin
      out_v_d      = 1'b1;
      out_value_d  = ram_rdata;
      out_status_d = deq_pkg::ST_ITEM;
      out_last_d   = cmd_i.load_last;
    end else if (rsp_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    bwd_q        <= bwd_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  deq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_value_i),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(rd_slot),
    .rdata_o(ram_rdata)
  );

  assign rsp_valid_o  = out_v_q;
  assign item_value_o = out_value_q;
  assign rsp_status_o = out_status_q;
  assign rsp_last_o   = out_last_q;

  // The fill count never exceeds the capacity.
  `DEQ_ASSERT(a_count_bound, count_q <= CountMax, "entry count above capacity")
  // The head slot stays inside the buffer.
  `DEQ_ASSERT(a_head_bound, head_q <= IdxMax, "head index out of range")
  // A push is never applied to a full queue.
  `DEQ_ASSERT_IMPL(a_no_push_full,
                   cmd_i.op == deq_pkg::OP_PUSH_FRONT || cmd_i.op == deq_pkg::OP_PUSH_BACK,
                   count_q != CountMax, "push applied while full")

endmodule

// ===== hw/rtl/double_ended_queue_with_dump.sv =====
// Double-ended queue of signed 32-bit values held in a circular buffer of DEPTH entries.
// Requests arrive on req_i (valid/ready): push front/back, pop front/back, dump forward or
// backward. Results leave on rsp_o (valid/ready) with item_value, status and a last flag.
// Push, pop, unknown codes and any request on an empty queue give one result that appears
// in the cycle after the transaction; a new request is taken every cycle while rsp_o drains.
// A dump of N entries gives N results; the first passes through the dump state, the RAM
// read register and the output register, and the rest follow one per cycle while rsp_o
// takes them, paced by the single registered read port. No request is taken during a dump.
// A full queue drops a push and reports status full; an empty queue reports status empty.
// Reset clears the head index, entry count and result valid flag; entry contents are
// left as they are and are only read where live entries sit.
// When rsp_o stalls, the pending result stays in the output register, req_i is held off and
// a dump pauses with at most one entry waiting in the RAM read register.
module double_ended_queue_with_dump #(
  parameter int DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  deq_pkg::ctrl_cmd_t  cmd;
  deq_pkg::dp_status_t dp_status;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_type_i (req_i.req_type),
    .req_ready_o(req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  deq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .push_value_i(req_i.push_value),
    .rsp_ready_i (rsp_o.ready),
    .status_o    (dp_status),
    .rsp_valid_o (rsp_o.valid),
    .item_value_o(rsp_o.item_value),
    .rsp_status_o(rsp_o.status),
    .rsp_last_o  (rsp_o.last)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the double-ended queue with forward and backward dump.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int RANDOM_REQUESTS = 286;
  localparam int QUIET_TAIL = 60;
  localparam int DRAIN_CYCLES = 8;

  // Request codes the block has no operation for; they must be answered as done.
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic signed [31:0] value;
    deq_pkg::status_e   status;
    logic               last;
  } deq_result_t;

  // Tracks the queue contents and the results each request must produce.
  class deque_scoreboard;
    logic [31:0]    slots [DEPTH];
    int unsigned    head;
    int unsigned    count;
    deq_result_t    expected [$];
    int unsigned    failures;
    int unsigned    requests;
    int unsigned    results_seen;
    int unsigned    dumps;
    int unsigned    dropped_pushes;
    int unsigned    empty_replies;

    function new();
      head = 0;
      count = 0;
    endfunction

    function void add_expect(logic [31:0] value, deq_pkg::status_e status, logic last);
      deq_result_t res;
      res.value = value;
      res.status = status;
      res.last = last;
      expected.push_back(res);
    endfunction

    // Updates the queue for one accepted request and queues its results.
    function void note_request(logic [2:0] kind, logic [31:0] value);
      int unsigned off;
      requests++;
      case (kind)
        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
          if (count >= DEPTH) begin
            dropped_pushes++;
            add_expect('0, deq_pkg::ST_FULL, 1'b1);
          end else begin
            if (kind == deq_pkg::REQ_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              slots[head] = value;
            end else begin
              slots[(head + count) % DEPTH] = value;
            end
            count++;
            add_expect('0, deq_pkg::ST_DONE, 1'b1);
          end
        end
        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
          if (count == 0) begin
            empty_replies++;
            add_expect('0, deq_pkg::ST_EMPTY, 1'b1);
          end else begin
            if (kind == deq_pkg::REQ_POP_FRONT) head = (head + 1) % DEPTH;
            count--;
            add_expect('0, deq_pkg::ST_DONE, 1'b1);
          end
        end
        deq_pkg::REQ_DUMP_FWD, deq_pkg::REQ_DUMP_BWD: begin
          if (count == 0) begin
            empty_replies++;
            add_expect('0, deq_pkg::ST_EMPTY, 1'b1);
          end else begin
            dumps++;
            for (int unsigned i = 0; i < count; i++) begin
              off = (kind == deq_pkg::REQ_DUMP_FWD) ? i : count - 1 - i;
              add_expect(slots[(head + off) % DEPTH], deq_pkg::ST_ITEM, i + 1 == count);
            end
          end
        end
        default: add_expect('0, deq_pkg::ST_DONE, 1'b1);
      endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(logic [31:0] value, logic [1:0] status, logic last);
      deq_result_t want;
      results_seen++;
      if (expected.size() == 0) begin
        $error("Unexpected result: item_value %0d status %0d last %0d",
               $signed(value), status, last);
        failures++;
        return;
      end
      want = expected.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
      if (value !== want.value) begin
        $error("item_value: expected %0d, actual %0d", want.value, $signed(value));
        failures++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet = 1'b0;
  int unsigned cycle_count = 0;
  deque_scoreboard sb = new();

  deq_req_if req_if ();
  deq_rsp_if rsp_if ();

  double_ended_queue_with_dump #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Clock and cycle counter.
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog for a hung handshake.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Result receiver: ready drops for random bursts while idling is enabled.
  always begin
    @(posedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      rsp_if.ready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    rsp_if.ready <= 1'b1;
  end

  // Outputs are stable at the falling edge, so each transaction is sampled there.
  always @(negedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.item_value, rsp_if.status, rsp_if.last);
    end
  end

  // Presents one request, with an optional idle burst first, and waits for its transaction.
  task automatic send_request(input logic [2:0] kind, input logic [31:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.push_value <= value;
    do @(negedge clk_i); while (!req_if.ready);
    sb.note_request(kind, value);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic that alternates between filling the queue to full and draining it.
  task automatic run_random(input int n);
    bit          filling;
    int unsigned roll;
    logic [2:0]  kind;
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i == n - QUIET_TAIL) quiet = 1'b1;
      if (filling && sb.count == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && sb.count == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 82 : 10)) begin
        kind = $urandom_range(0, 1) ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK;
      end else if (roll < (filling ? 92 : 88)) begin
        kind = $urandom_range(0, 1) ? deq_pkg::REQ_POP_FRONT : deq_pkg::REQ_POP_BACK;
      end else if (roll < 96) begin
        kind = $urandom_range(0, 1) ? deq_pkg::REQ_DUMP_FWD : deq_pkg::REQ_DUMP_BWD;
      end else begin
        kind = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
      end
      send_request(kind, pick_value());
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.req_type <= deq_pkg::REQ_PUSH_FRONT;
    req_if.push_value <= '0;
    rsp_if.ready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-queue replies and unused request codes.
    send_request(deq_pkg::REQ_POP_FRONT, $urandom);
    send_request(deq_pkg::REQ_POP_BACK, $urandom);
    send_request(deq_pkg::REQ_DUMP_FWD, $urandom);
    send_request(deq_pkg::REQ_DUMP_BWD, $urandom);
    send_request(REQ_UNUSED_6, $urandom);
    send_request(REQ_UNUSED_7, $urandom);

    // Value extremes at both ends, then dumps in both directions.
    send_request(deq_pkg::REQ_PUSH_BACK, 32'h7fff_ffff);
    send_request(deq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(deq_pkg::REQ_PUSH_BACK, 32'h0000_0000);
    send_request(deq_pkg::REQ_PUSH_FRONT, 32'hffff_ffff);
    send_request(deq_pkg::REQ_PUSH_BACK, 32'h5555_5555);
    send_request(deq_pkg::REQ_PUSH_FRONT, 32'haaaa_aaaa);
    send_request(deq_pkg::REQ_DUMP_FWD, '0);
    send_request(deq_pkg::REQ_DUMP_BWD, '0);
    send_request(REQ_UNUSED_6, '0);

    // Drain from both ends past empty.
    send_request(deq_pkg::REQ_POP_FRONT, '0);
    send_request(deq_pkg::REQ_POP_BACK, '0);
    send_request(deq_pkg::REQ_DUMP_BWD, '0);
    send_request(deq_pkg::REQ_POP_FRONT, '0);
    send_request(deq_pkg::REQ_POP_BACK, '0);
    send_request(deq_pkg::REQ_DUMP_FWD, '0);
    send_request(deq_pkg::REQ_POP_FRONT, '0);
    send_request(deq_pkg::REQ_POP_BACK, '0);
    send_request(deq_pkg::REQ_POP_FRONT, '0);

    run_random(RANDOM_REQUESTS);

    // Let the last results arrive, then let the block idle before reporting.
    req_if.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results, including %0d non-empty dumps.",
             sb.requests, sb.results_seen, sb.dumps);
    $display("Saw %0d pushes dropped on a full queue and %0d empty-queue replies.",
             sb.dropped_pushes, sb.empty_replies);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
